// ===== rtl/core/sges_pkg.sv =====
`timescale 1ns / 1ps
package sges_pkg;

   localparam int ROW_W   = 10;
   localparam int LUMA_W  = 8;
   localparam int GRAD_W  = 10;
   localparam int COUNT_W = 10;
   localparam int EDGE_W  = 2;
   localparam int REQ_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam int MAX_ROWS_DEFAULT = 1024;
   localparam int ROW_MAX   = (1 << ROW_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_END    = 2'd2;

   localparam logic [EDGE_W-1:0] EDGE_BORDER  = 2'd0;
   localparam logic [EDGE_W-1:0] EDGE_RISING  = 2'd1;
   localparam logic [EDGE_W-1:0] EDGE_FALLING = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_MEDIAN     = 1'd1;

   localparam logic [LUMA_W-1:0] THRESHOLD_RESET = 8'd16;

   function automatic logic [LUMA_W-1:0] median3(input logic [LUMA_W-1:0] a,
                                                   input logic [LUMA_W-1:0] b,
                                                   input logic [LUMA_W-1:0] c);
      logic [LUMA_W-1:0] lo;
      logic [LUMA_W-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) begin
         median3 = lo;
      end else if (c >= hi) begin
         median3 = hi;
      end else begin
         median3 = c;
      end
   endfunction

endpackage

// ===== rtl/core/sges_if.sv =====
`timescale 1ns / 1ps
interface sges_req_if;
   logic                              valid;
   logic                              ready;
   logic [sges_pkg::REQ_W-1:0]        req_type;
   logic [sges_pkg::ROW_W-1:0]        row;
   logic [sges_pkg::LUMA_W-1:0]       luma_center;
   logic [sges_pkg::LUMA_W-1:0]       luma_above;
   logic [sges_pkg::LUMA_W-1:0]       luma_below;

   modport source (output valid, req_type, row, luma_center, luma_above, luma_below,
                   input ready);
   modport sink   (input valid, req_type, row, luma_center, luma_above, luma_below,
                   output ready);
endinterface

interface sges_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sges_pkg::ROW_W-1:0]        seg_start_row;
   logic [sges_pkg::ROW_W-1:0]        seg_end_row;
   logic [sges_pkg::EDGE_W-1:0]       start_edge;
   logic [sges_pkg::EDGE_W-1:0]       end_edge;
   logic [sges_pkg::COUNT_W-1:0]      sample_count;
   logic                              final_segment;

   modport source (output valid, seg_start_row, seg_end_row, start_edge, end_edge,
                          sample_count, final_segment,
                   input ready);
   modport sink   (input valid, seg_start_row, seg_end_row, start_edge, end_edge,
                         sample_count, final_segment,
                   output ready);
endinterface

// ===== rtl/core/scanline_gradient_edge_segmenter.sv =====
`timescale 1ns / 1ps
// Splits a vertical scanline of luma samples into segments at gradient peaks. A start
// transfer opens the scanline, each sample transfer may close one segment at a rising or
// falling peak, and an end transfer closes the final border segment. Every request passes
// an input register and then one short compare-and-update step into the result register,
// so one request is taken per clock and its result is held in the result register;
// the only stall comes from a held result register when the response side is not ready.
module scanline_gradient_edge_segmenter #(
   parameter int MAX_ROWS = sges_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   sges_req_if.sink                            req,
   sges_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [sges_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sges_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ROW_W   = sges_pkg::ROW_W;
   localparam int LUMA_W  = sges_pkg::LUMA_W;
   localparam int GRAD_W  = sges_pkg::GRAD_W;
   localparam int COUNT_W = sges_pkg::COUNT_W;
   localparam int EDGE_W  = sges_pkg::EDGE_W;
   localparam int RowLimitInt = (MAX_ROWS - 1 > sges_pkg::ROW_MAX) ?
                                sges_pkg::ROW_MAX : MAX_ROWS - 1;
   localparam logic [ROW_W-1:0] RowLimit = ROW_W'(RowLimitInt);

   logic [LUMA_W-1:0]          threshold_ff;
   logic                       use_median_ff;

   logic                       in_valid_ff;
   logic [sges_pkg::REQ_W-1:0] in_type_ff;
   logic [ROW_W-1:0]           in_row_ff;
   logic [LUMA_W-1:0]          in_center_ff;
   logic [LUMA_W-1:0]          in_above_ff;
   logic [LUMA_W-1:0]          in_below_ff;

   logic [LUMA_W-1:0]          prev_luma_ff, prev_luma_in;
   logic signed [GRAD_W-1:0]   grad_max_ff, grad_max_in;
   logic signed [GRAD_W-1:0]   grad_min_ff, grad_min_in;
   logic [ROW_W-1:0]           peak_row_ff, peak_row_in;
   logic [COUNT_W-1:0]         point_count_ff, point_count_in;
   logic [ROW_W-1:0]           open_start_row_ff, open_start_row_in;
   logic [EDGE_W-1:0]          open_start_edge_ff, open_start_edge_in;
   logic [ROW_W-1:0]           first_row_ff, first_row_in;
   logic                       scan_open_ff, scan_open_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]           rsp_start_row_ff, rsp_start_row_in;
   logic [ROW_W-1:0]           rsp_end_row_ff, rsp_end_row_in;
   logic [EDGE_W-1:0]          rsp_start_edge_ff, rsp_start_edge_in;
   logic [EDGE_W-1:0]          rsp_end_edge_ff, rsp_end_edge_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                       rsp_final_ff, rsp_final_in;

   logic                       advance;
   logic                       consume;
   logic [ROW_W-1:0]           row_clamped;

   assign advance     = !rsp_valid_ff || rsp.ready;
   assign consume     = in_valid_ff && advance;
   assign req.ready   = !in_valid_ff || advance;
   assign row_clamped = (req.row > RowLimit) ? RowLimit : req.row;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.seg_start_row = rsp_start_row_ff;
   assign rsp.seg_end_row   = rsp_end_row_ff;
   assign rsp.start_edge    = rsp_start_edge_ff;
   assign rsp.end_edge      = rsp_end_edge_ff;
   assign rsp.sample_count  = rsp_count_ff;
   assign rsp.final_segment = rsp_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= sges_pkg::THRESHOLD_RESET;
         use_median_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            sges_pkg::CSR_EDGE_THRESHOLD: threshold_ff  <= csr_wdata;
            sges_pkg::CSR_USE_MEDIAN:     use_median_ff <= csr_wdata[0];
            default:                      threshold_ff  <= threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_type_ff   <= req.req_type;
         in_row_ff    <= row_clamped;
         in_center_ff <= req.luma_center;
         in_above_ff  <= req.luma_above;
         in_below_ff  <= req.luma_below;
      end
   end

   always_comb begin
      logic [LUMA_W-1:0]        luma;
      logic signed [GRAD_W-1:0] thr;
      logic signed [GRAD_W-1:0] diff;
      logic [ROW_W-1:0]         peak;
      logic [COUNT_W-1:0]       count;
      logic                     rise_hit;
      logic                     fall_hit;
      logic signed [GRAD_W-1:0] gmax1;
      logic signed [GRAD_W-1:0] gmin1;

      prev_luma_in       = prev_luma_ff;
      grad_max_in        = grad_max_ff;
      grad_min_in        = grad_min_ff;
      peak_row_in        = peak_row_ff;
      point_count_in     = point_count_ff;
      open_start_row_in  = open_start_row_ff;
      open_start_edge_in = open_start_edge_ff;
      first_row_in       = first_row_ff;
      scan_open_in       = scan_open_ff;

      rsp_valid_in      = 1'b0;
      rsp_start_row_in  = open_start_row_ff;
      rsp_end_row_in    = peak_row_ff;
      rsp_start_edge_in = open_start_edge_ff;
      rsp_end_edge_in   = sges_pkg::EDGE_BORDER;
      rsp_count_in      = point_count_ff;
      rsp_final_in      = 1'b0;

      luma  = use_median_ff ? sges_pkg::median3(in_above_ff, in_center_ff, in_below_ff)
                            : in_center_ff;
      thr   = $signed({{(GRAD_W-LUMA_W){1'b0}}, threshold_ff});
      diff  = $signed({{(GRAD_W-LUMA_W){1'b0}}, luma})
            - $signed({{(GRAD_W-LUMA_W){1'b0}}, prev_luma_ff});
      peak  = (in_row_ff != '0) ? in_row_ff - ROW_W'(1) : '0;
      count = (point_count_ff < sges_pkg::COUNT_MAX) ? point_count_ff + COUNT_W'(1)
                                                     : point_count_ff;
      rise_hit = diff > grad_max_ff;
      gmax1    = rise_hit ? diff : grad_max_ff;
      gmin1    = rise_hit ? thr : grad_min_ff;
      fall_hit = diff < gmin1;

      if (consume) begin
         case (in_type_ff)
            sges_pkg::REQ_START: begin
               prev_luma_in       = in_center_ff;
               grad_max_in        = -thr;
               grad_min_in        = thr;
               peak_row_in        = '0;
               point_count_in     = '0;
               open_start_row_in  = in_row_ff;
               open_start_edge_in = sges_pkg::EDGE_BORDER;
               first_row_in       = in_row_ff;
               scan_open_in       = 1'b1;
            end
            sges_pkg::REQ_END: begin
               if (scan_open_ff) begin
                  scan_open_in      = 1'b0;
                  rsp_valid_in      = in_row_ff > first_row_ff;
                  rsp_end_row_in    = in_row_ff;
                  rsp_end_edge_in   = sges_pkg::EDGE_BORDER;
                  rsp_count_in      = (in_row_ff >= open_start_row_ff) ?
                                      COUNT_W'((in_row_ff - open_start_row_ff) >> 1) : '0;
                  rsp_final_in      = 1'b1;
               end
            end
            sges_pkg::REQ_SAMPLE: begin
               if (scan_open_ff) begin
                  prev_luma_in   = luma;
                  point_count_in = count;
                  rsp_count_in   = count;
                  if (rise_hit) begin
                     if (grad_min_ff < -thr) begin
                        rsp_valid_in       = 1'b1;
                        rsp_end_edge_in    = sges_pkg::EDGE_FALLING;
                        open_start_row_in  = peak_row_ff;
                        open_start_edge_in = sges_pkg::EDGE_FALLING;
                        point_count_in     = '0;
                     end
                     grad_max_in = diff;
                     grad_min_in = thr;
                     peak_row_in = peak;
                  end
                  if (fall_hit) begin
                     // A rising peak cannot close here when the first update already fired.
                     if (gmax1 > thr) begin
                        rsp_valid_in       = 1'b1;
                        rsp_end_edge_in    = sges_pkg::EDGE_RISING;
                        open_start_row_in  = peak_row_ff;
                        open_start_edge_in = sges_pkg::EDGE_RISING;
                        point_count_in     = '0;
                     end
                     grad_min_in = diff;
                     grad_max_in = -thr;
                     peak_row_in = peak;
                  end
               end
            end
            default: begin
               scan_open_in = scan_open_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_luma_ff       <= '0;
         grad_max_ff        <= '0;
         grad_min_ff        <= '0;
         peak_row_ff        <= '0;
         point_count_ff     <= '0;
         open_start_row_ff  <= '0;
         open_start_edge_ff <= sges_pkg::EDGE_BORDER;
         first_row_ff       <= '0;
         scan_open_ff       <= 1'b0;
      end else begin
         prev_luma_ff       <= prev_luma_in;
         grad_max_ff        <= grad_max_in;
         grad_min_ff        <= grad_min_in;
         peak_row_ff        <= peak_row_in;
         point_count_ff     <= point_count_in;
         open_start_row_ff  <= open_start_row_in;
         open_start_edge_ff <= open_start_edge_in;
         first_row_ff       <= first_row_in;
         scan_open_ff       <= scan_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_start_row_ff  <= rsp_start_row_in;
         rsp_end_row_ff    <= rsp_end_row_in;
         rsp_start_edge_ff <= rsp_start_edge_in;
         rsp_end_edge_ff   <= rsp_end_edge_in;
         rsp_count_ff      <= rsp_count_in;
         rsp_final_ff      <= rsp_final_in;
      end
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

   localparam int LIMIT_CYCLES = 250000;
   localparam logic [sges_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [sges_pkg::REQ_W-1:0]  kind;
      logic [sges_pkg::ROW_W-1:0]  row;
      logic [sges_pkg::LUMA_W-1:0] lc;
      logic [sges_pkg::LUMA_W-1:0] la;
      logic [sges_pkg::LUMA_W-1:0] lb;
   } scan_req_type;

   typedef struct packed {
      logic [sges_pkg::ROW_W-1:0]   start_row;
      logic [sges_pkg::ROW_W-1:0]   end_row;
      logic [sges_pkg::EDGE_W-1:0]  start_edge;
      logic [sges_pkg::EDGE_W-1:0]  end_edge;
      logic [sges_pkg::COUNT_W-1:0] count;
      logic                         fin;
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [sges_pkg::CSR_IDX_W-1:0]  csr_index = sges_pkg::CSR_EDGE_THRESHOLD;
   logic [sges_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   sges_req_if req_ch();
   sges_rsp_if rsp_ch();

   scanline_gradient_edge_segmenter dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   scan_req_type pend_q[$];
   segment_type  seg_q[$];

   // Segmenter state mirrored by the predictor.
   logic [sges_pkg::LUMA_W-1:0]  thr_reg = sges_pkg::THRESHOLD_RESET;
   logic                         med_reg = 1'b0;
   logic [sges_pkg::LUMA_W-1:0]  last_luma = '0;
   int                           gmax = 0;
   int                           gmin = 0;
   logic [sges_pkg::ROW_W-1:0]   peak_at = '0;
   logic [sges_pkg::COUNT_W-1:0] pts = '0;
   logic [sges_pkg::ROW_W-1:0]   seg_row = '0;
   logic [sges_pkg::EDGE_W-1:0]  seg_edge = sges_pkg::EDGE_BORDER;
   logic [sges_pkg::ROW_W-1:0]   scan_first = '0;
   bit                           scan_live = 1'b0;

   bit req_took = 1'b0;
   bit quiet = 1'b0;
   int src_gap = 0;
   int rsp_gap = 0;
   int hold_rsp_cycles = 0;
   int bad = 0;
   int n_in = 0;
   int n_seg = 0;
   int n_final = 0;
   int queued = 0;
   int cycles = 0;

   scan_req_type taken;
   segment_type  got;
   segment_type  want;

   function automatic scan_req_type mk(logic [sges_pkg::REQ_W-1:0] kind, int row, int lc,
                                       int la, int lb);
      scan_req_type it;
      it.kind = kind;
      it.row  = row[sges_pkg::ROW_W-1:0];
      it.lc   = lc[sges_pkg::LUMA_W-1:0];
      it.la   = la[sges_pkg::LUMA_W-1:0];
      it.lb   = lb[sges_pkg::LUMA_W-1:0];
      return it;
   endfunction

   function automatic int clip8(int v);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
   endfunction

   task automatic emit_segment(logic [sges_pkg::ROW_W-1:0] s, logic [sges_pkg::ROW_W-1:0] e,
                               logic [sges_pkg::EDGE_W-1:0] se,
                               logic [sges_pkg::EDGE_W-1:0] ee,
                               logic [sges_pkg::COUNT_W-1:0] cnt, logic fin);
      segment_type item;
      item = '{s, e, se, ee, cnt, fin};
      seg_q.insert(seg_q.size(), item);
   endtask

   task automatic predict_segment(scan_req_type it);
      int thr;
      int y;
      int diff;
      int lo;
      int hi;
      logic [sges_pkg::ROW_W-1:0] pk;
      thr = thr_reg;
      case (it.kind)
         sges_pkg::REQ_START: begin
            last_luma  = it.lc;
            gmax       = -thr;
            gmin       = thr;
            peak_at    = '0;
            pts        = '0;
            seg_row    = it.row;
            seg_edge   = sges_pkg::EDGE_BORDER;
            scan_first = it.row;
            scan_live  = 1'b1;
         end
         sges_pkg::REQ_END: begin
            if (scan_live) begin
               if (it.row > scan_first) begin
                  emit_segment(seg_row, it.row, seg_edge, sges_pkg::EDGE_BORDER,
                               (it.row >= seg_row) ? (it.row - seg_row) >> 1 : '0, 1'b1);
               end
               scan_live = 1'b0;
            end
         end
         sges_pkg::REQ_SAMPLE: begin
            if (scan_live) begin
               lo = (it.la < it.lb) ? it.la : it.lb;
               hi = (it.la < it.lb) ? it.lb : it.la;
               if (med_reg) begin
                  y = (it.lc < lo) ? lo : ((it.lc > hi) ? hi : it.lc);
               end else begin
                  y = it.lc;
               end
               diff = y - int'(last_luma);
               pk = (it.row != 0) ? it.row - 1'b1 : '0;
               if (pts != sges_pkg::COUNT_MAX) begin
                  pts = pts + 1'b1;
               end
               if (diff > gmax) begin
                  if (gmin < -thr) begin
                     emit_segment(seg_row, peak_at, seg_edge, sges_pkg::EDGE_FALLING, pts, 1'b0);
                     seg_row  = peak_at;
                     seg_edge = sges_pkg::EDGE_FALLING;
                     pts      = '0;
                  end
                  gmax    = diff;
                  gmin    = thr;
                  peak_at = pk;
               end
               if (diff < gmin) begin
                  if (gmax > thr) begin
                     emit_segment(seg_row, peak_at, seg_edge, sges_pkg::EDGE_RISING, pts, 1'b0);
                     seg_row  = peak_at;
                     seg_edge = sges_pkg::EDGE_RISING;
                     pts      = '0;
                  end
                  gmin    = diff;
                  gmax    = -thr;
                  peak_at = pk;
               end
               last_luma = y[sges_pkg::LUMA_W-1:0];
            end
         end
         default: begin
         end
      endcase
   endtask

   // Request side: capture the transfer at the rising edge, drive at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken = pend_q.pop_front();
         req_took = 1'b1;
         n_in++;
         predict_segment(taken);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.req_type    <= sges_pkg::REQ_START;
         req_ch.row         <= '0;
         req_ch.luma_center <= '0;
         req_ch.luma_above  <= '0;
         req_ch.luma_below  <= '0;
      end else if (!(req_ch.valid && !req_took)) begin
         req_took = 1'b0;
         if (src_gap > 0) begin
            src_gap--;
            req_ch.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            src_gap = $urandom_range(1, 17) - 1;
            req_ch.valid <= 1'b0;
         end else if (pend_q.size() != 0) begin
            req_ch.req_type    <= pend_q[0].kind;
            req_ch.row         <= pend_q[0].row;
            req_ch.luma_center <= pend_q[0].lc;
            req_ch.luma_above  <= pend_q[0].la;
            req_ch.luma_below  <= pend_q[0].lb;
            req_ch.valid       <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_rsp_cycles > 0) begin
         hold_rsp_cycles--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         rsp_gap = $urandom_range(1, 17) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.seg_start_row, rsp_ch.seg_end_row, rsp_ch.start_edge,
                 rsp_ch.end_edge, rsp_ch.sample_count, rsp_ch.final_segment};
         n_seg++;
         if (got.fin) begin
            n_final++;
         end
         if (seg_q.size() == 0) begin
            bad++;
            if (bad <= 10) begin
               $display("%0t: segment with none expected: start %0d end %0d edges %0d/%0d cnt %0d fin %0d",
                        $realtime, got.start_row, got.end_row, got.start_edge, got.end_edge,
                        got.count, got.fin);
            end
         end else begin
            want = seg_q.pop_front();
            if (got.start_row !== want.start_row || got.end_row !== want.end_row ||
                got.start_edge !== want.start_edge || got.end_edge !== want.end_edge ||
                got.count !== want.count || got.fin !== want.fin) begin
               bad++;
               if (bad <= 10) begin
                  $display("%0t: segment mismatch: expected start %0d end %0d edges %0d/%0d cnt %0d fin %0d",
                           $realtime, want.start_row, want.end_row, want.start_edge,
                           want.end_edge, want.count, want.fin);
                  $display("            got      start %0d end %0d edges %0d/%0d cnt %0d fin %0d",
                           got.start_row, got.end_row, got.start_edge, got.end_edge,
                           got.count, got.fin);
               end
            end
         end
      end
   end

   initial begin
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Run exceeded %0d cycles with %0d segments outstanding.", LIMIT_CYCLES,
               seg_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   task automatic settle();
      while (pend_q.size() != 0 || req_ch.valid || seg_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [sges_pkg::CSR_IDX_W-1:0] idx,
                            logic [sges_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == sges_pkg::CSR_EDGE_THRESHOLD) begin
         thr_reg = val;
      end else begin
         med_reg = val[0];
      end
   endtask

   task automatic push(scan_req_type it);
      pend_q.insert(pend_q.size(), it);
      queued++;
   endtask

   task automatic push_noise();
      push(mk(sges_pkg::REQ_W'($urandom_range(0, 3)), $urandom_range(0, 1023),
              $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
   endtask

   // One scanline with a random walk of luma, occasionally broken or cut short.
   task automatic push_scanline(int n);
      int r;
      int y;
      int step;
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 300);
      y = $urandom_range(0, 255);
      push(mk(sges_pkg::REQ_START, r, y, $urandom_range(0, 255), $urandom_range(0, 255)));
      for (int i = 0; i < n; i++) begin
         r = r + $urandom_range(1, 2);
         if (r > 1023) begin
            r = 1023;
         end
         if ($urandom_range(0, 3) == 0) begin
            step = $urandom_range(30, 140);
            y = clip8($urandom_range(0, 1) ? y + step : y - step);
         end else begin
            y = clip8(y + $urandom_range(0, 8) - 4);
         end
         if ($urandom_range(0, 24) == 0) begin
            push_noise();
         end
         if ($urandom_range(0, 9) == 0) begin
            push(mk(sges_pkg::REQ_SAMPLE, r, y, $urandom_range(0, 255), $urandom_range(0, 255)));
         end else begin
            push(mk(sges_pkg::REQ_SAMPLE, r, y, clip8(y + $urandom_range(0, 20) - 10),
                    clip8(y + $urandom_range(0, 20) - 10)));
         end
      end
      if ($urandom_range(0, 9) != 0) begin
         push(mk(sges_pkg::REQ_END, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : r,
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
      end
   endtask

   task automatic push_random(int target);
      int stop;
      stop = queued + target;
      while (queued < stop) begin
         if ($urandom_range(0, 7) == 0) begin
            push_noise();
         end else begin
            push_scanline($urandom_range(2, 30));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: no open scanline, unknown request, extremes of rows and luma,
      // peak at row zero, restart while open, ends at or below the first row,
      // and an end row below the open segment.
      push(mk(sges_pkg::REQ_SAMPLE, 5, 200, 0, 0));
      push(mk(sges_pkg::REQ_END, 900, 0, 0, 0));
      push(mk(REQ_UNKNOWN, 1023, 255, 255, 255));
      push(mk(sges_pkg::REQ_START, 0, 0, 0, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 0, 255, 0, 255));
      push(mk(sges_pkg::REQ_SAMPLE, 1, 0, 255, 0));
      push(mk(REQ_UNKNOWN, 3, 17, 0, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 2, 255, 255, 255));
      push(mk(sges_pkg::REQ_START, 1000, 128, 0, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 1023, 128, 255, 0));
      push(mk(sges_pkg::REQ_END, 1023, 0, 0, 0));
      push(mk(sges_pkg::REQ_START, 500, 10, 0, 0));
      push(mk(sges_pkg::REQ_END, 500, 0, 0, 0));
      push(mk(sges_pkg::REQ_START, 500, 10, 0, 0));
      push(mk(sges_pkg::REQ_END, 499, 0, 0, 0));
      push(mk(sges_pkg::REQ_START, 10, 50, 0, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 40, 200, 0, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 41, 200, 0, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 42, 20, 0, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 43, 20, 0, 0));
      push(mk(sges_pkg::REQ_END, 20, 0, 0, 0));
      settle();

      write_csr(sges_pkg::CSR_EDGE_THRESHOLD, 8'd0);
      write_csr(sges_pkg::CSR_USE_MEDIAN, 8'd1);
      push(mk(sges_pkg::REQ_START, 3, 100, 0, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 4, 100, 255, 0));
      push(mk(sges_pkg::REQ_SAMPLE, 5, 0, 255, 255));
      push(mk(sges_pkg::REQ_SAMPLE, 6, 255, 0, 0));
      push_random(70);
      settle();

      write_csr(sges_pkg::CSR_EDGE_THRESHOLD, 8'd255);
      write_csr(sges_pkg::CSR_USE_MEDIAN, 8'd0);
      push_random(30);
      settle();

      // The response side holds off while requests keep coming.
      write_csr(sges_pkg::CSR_EDGE_THRESHOLD, 8'd12);
      push_random(50);
      @(posedge clock);
      hold_rsp_cycles = 400;
      while (pend_q.size() != 0 || req_ch.valid || seg_q.size() != 0) begin
         @(posedge clock);
      end
      push_random(50);
      settle();

      for (int p = 0; p < 3; p++) begin
         write_csr(sges_pkg::CSR_EDGE_THRESHOLD, sges_pkg::CSR_DATA_W'($urandom_range(0, 60)));
         write_csr(sges_pkg::CSR_USE_MEDIAN, sges_pkg::CSR_DATA_W'($urandom_range(0, 1)));
         push_random(50);
         settle();
      end

      quiet = 1'b1;
      write_csr(sges_pkg::CSR_EDGE_THRESHOLD, 8'd8);
      write_csr(sges_pkg::CSR_USE_MEDIAN, 8'd1);
      push_random(60);
      while (pend_q.size() != 0 || req_ch.valid) begin
         @(posedge clock);
      end
      for (int k = 0; k < 2000 && seg_q.size() != 0; k++) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (seg_q.size() != 0) begin
         bad++;
         $display("%0d expected segments never arrived.", seg_q.size());
      end

      $display("Sent %0d request transfers and checked %0d segments, %0d of them closing.",
               n_in, n_seg, n_final);
      $display("Thresholds 0 to 255 with center and median luma, restarts, stray requests, stalls.");
      if (bad == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d failures.", bad);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== scanline_gradient_edge_segmenter.f =====
rtl/core/sges_pkg.sv
rtl/core/sges_if.sv
rtl/core/scanline_gradient_edge_segmenter.sv
dv/tb.sv
